[rtl/core/bmm_pkg.sv]
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the binned median / MAD standardiser.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_BINS    = 32;

    localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
    localparam int FILL_W      = SAMPLE_AW + 1;
    localparam int BIN_W       = $clog2(MAX_BINS + 1);
    localparam int TBL_AW      = $clog2(MAX_BINS);
    localparam int EDGE_DEPTH  = MAX_BINS + 1;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);

    localparam int X_W         = 16;
    localparam int Y_W         = 32;
    localparam int EDGE_W      = X_W + 1;
    localparam int BC_W        = 6;
    localparam int ACC_W       = 22;
    localparam int SCALE_W     = 17;
    localparam int PROD_W      = Y_W + SCALE_W;

    localparam logic [SCALE_W-1:0] MAD_SCALE = 17'd97164;
    localparam logic [Y_W-1:0]     SIGN_BIAS = 32'h8000_0000;
    localparam logic [Y_W-1:0]     SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [Y_W-1:0]     SAT_NEG   = 32'h8000_0000;

    localparam int DIV_N_W     = 49;
    localparam int DIV_D_W     = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam logic KIND_FIT  = 1'b0;
    localparam logic KIND_RES  = 1'b1;
    localparam logic CFG_BIN_COUNT = 1'b0;
    localparam logic CFG_MAX_COUNT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_BINS = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_OVFL    = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_F_START, S_E_DIV, S_E_WAIT, S_E_LAST,
        S_B_EDGE, S_B_EDGE2, S_B_EDGE3, S_C_RD, S_C_CHK,
        S_S_INIT, S_S_OUTER, S_S_T, S_S_INNER, S_S_CMP,
        S_M_RD, S_M_A, S_M_B, S_M_USE, S_D_RD, S_D_WR,
        S_MUL, S_MUL2, S_B_NEXT, S_F_END,
        S_Q_START, S_Q_RD, S_Q_CMP, S_Q_SEL, S_Q_DIFF, S_Q_WAIT, S_OUT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_resp_t;

endpackage

[rtl/core/bmm_ram.sv]
// ----------------------------------------------------------------------------
// bmm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bmm_divider.sv]
// ----------------------------------------------------------------------------
// bmm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  bmm_pkg::div_req_t  req,
    output bmm_pkg::div_resp_t resp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [bmm_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [bmm_pkg::DIV_D_W-1:0]      rem_reg, rem_next;
    logic [bmm_pkg::DIV_D_W-1:0]      den_reg, den_next;
    logic [bmm_pkg::DIV_N_W-1:0]      num_reg, num_next;
    logic [bmm_pkg::DIV_N_W-1:0]      quo_reg, quo_next;
    logic [bmm_pkg::DIV_D_W:0]        rem_sh;
    logic [bmm_pkg::DIV_D_W:0]        rem_sub;
    logic                             fits;

    assign rem_sh  = {rem_reg, num_reg[bmm_pkg::DIV_N_W-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = bmm_pkg::DIV_CNT_W'(bmm_pkg::DIV_N_W);
                rem_next  = '0;
                den_next  = req.divisor;
                num_next  = req.dividend;
                quo_next  = '0;
            end
        end
        else
        begin
            rem_next = fits ? rem_sub[bmm_pkg::DIV_D_W-1:0] : rem_sh[bmm_pkg::DIV_D_W-1:0];
            num_next = {num_reg[bmm_pkg::DIV_N_W-2:0], 1'b0};
            quo_next = {quo_reg[bmm_pkg::DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bmm_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

[rtl/core/binned_median_mad_standardiser.sv]
// ----------------------------------------------------------------------------
// binned_median_mad_standardiser
// Stores (x, y) sample pairs, fits a median and scaled MAD per count bin, and
// standardises queried values against the fitted bin.
// ----------------------------------------------------------------------------
// A non-last load word is taken while the block is idle, and the block stays
// ready for the next word. A last load runs the fit: one divider pass for each
// bin edge but the top one, then for every bin a sweep over all stored samples
// and, for a bin that holds samples, two insertion sorts over its samples in
// the scratch RAM, the median reads and a deviation pass. A query searches the
// bin edges in turn and then, unless the bin's MAD is zero, divides on the
// shared 49-step divider. The block takes no word while a fit or a query is in
// progress; a finished result waits in the output register while the next word
// is taken.
// ----------------------------------------------------------------------------
module binned_median_mad_standardiser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [15:0]         x,
    input  logic signed [31:0]  y,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic signed [31:0]  residual,
    output logic [1:0]          status
);

    localparam int SAW = bmm_pkg::SAMPLE_AW;
    localparam int FW  = bmm_pkg::FILL_W;
    localparam int BW  = bmm_pkg::BIN_W;
    localparam int EW  = bmm_pkg::EDGE_W;
    localparam int YW  = bmm_pkg::Y_W;

    bmm_pkg::state_t state_reg, state_next;

    logic [bmm_pkg::BC_W-1:0] bin_count_reg, bin_count_next;
    logic [15:0]              max_count_reg, max_count_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic                     dropped_reg, dropped_next;
    logic [BW-1:0]            nb_reg, nb_next;
    logic [BW-1:0]            bin_reg, bin_next;
    logic [FW-1:0]            idx_reg, idx_next;
    logic [FW-1:0]            n_reg, n_next;
    logic [FW-1:0]            j_reg, j_next;
    logic                     pass_reg, pass_next;
    logic                     out_valid_reg, out_valid_next;

    logic [15:0]                       xq_reg, xq_next;
    logic [YW-1:0]                     yq_reg, yq_next;
    logic [YW-1:0]                     t_reg, t_next;
    logic [EW-1:0]                     lo_reg, lo_next;
    logic [EW-1:0]                     hi_reg, hi_next;
    logic [bmm_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [YW-1:0]                     a_reg, a_next;
    logic [YW-1:0]                     mb_reg, mb_next;
    logic [YW-1:0]                     med_reg, med_next;
    logic [bmm_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic signed [YW:0]                diff_reg, diff_next;
    logic [YW-1:0]                     madq_reg, madq_next;
    logic [YW-1:0]                     pres_reg, pres_next;
    logic [1:0]                        pst_reg, pst_next;
    logic                              pkind_reg, pkind_next;
    logic [YW-1:0]                     ores_reg, ores_next;
    logic [1:0]                        ost_reg, ost_next;
    logic                              okind_reg, okind_next;

    logic [YW-1:0] bin_median_reg [bmm_pkg::MAX_BINS];
    logic [YW-1:0] bin_mad_reg    [bmm_pkg::MAX_BINS];
    logic                          tbl_we;
    logic [bmm_pkg::TBL_AW-1:0]    tbl_addr;
    logic [YW-1:0]                 tbl_med, tbl_mad;

    logic                 smp_we;
    logic [SAW-1:0]       smp_waddr, smp_raddr;
    logic [15:0]          xs_rdata;
    logic [YW-1:0]        ys_rdata;
    logic                 scr_we;
    logic [SAW-1:0]       scr_waddr, scr_raddr;
    logic [YW-1:0]        scr_wdata, scr_rdata;
    logic                 edg_we;
    logic [bmm_pkg::EDGE_AW-1:0] edg_waddr, edg_raddr;
    logic [EW-1:0]        edg_wdata, edg_rdata;

    bmm_pkg::div_req_t  div_req;
    bmm_pkg::div_resp_t div_resp;

    logic [BW-1:0]                 nb_min, nb_calc;
    logic [bmm_pkg::TBL_AW-1:0]    qbin;
    logic [YW:0]                   med_sum;
    logic [bmm_pkg::PROD_W-1:0]    prod_rnd;
    logic [YW:0]                   mag;
    logic [YW-1:0]                 q_lo;

    bmm_ram #(.WIDTH(16), .DEPTH(bmm_pkg::MAX_SAMPLES)) u_x_store (
        .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(x),
        .raddr(smp_raddr), .rdata(xs_rdata)
    );

    bmm_ram #(.WIDTH(YW), .DEPTH(bmm_pkg::MAX_SAMPLES)) u_y_store (
        .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(y),
        .raddr(smp_raddr), .rdata(ys_rdata)
    );

    bmm_ram #(.WIDTH(YW), .DEPTH(bmm_pkg::MAX_SAMPLES)) u_scratch (
        .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );

    bmm_ram #(.WIDTH(EW), .DEPTH(bmm_pkg::EDGE_DEPTH)) u_edges (
        .clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
        .raddr(edg_raddr), .rdata(edg_rdata)
    );

    bmm_divider u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .resp(div_resp)
    );

    assign nb_min   = ({10'b0, bin_count_reg} > max_count_reg) ? max_count_reg[BW-1:0]
                                                              : BW'(bin_count_reg);
    assign nb_calc  = (nb_min > BW'(bmm_pkg::MAX_BINS)) ? BW'(bmm_pkg::MAX_BINS) : nb_min;
    assign qbin     = bmm_pkg::TBL_AW'(bin_reg - 1'b1);
    assign med_sum  = {1'b0, a_reg} + {1'b0, scr_rdata};
    assign prod_rnd = prod_reg + bmm_pkg::PROD_W'(32768);
    assign mag      = diff_reg[YW] ? YW'(0) - diff_reg : diff_reg;
    assign q_lo     = div_resp.quotient[YW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        bin_count_next = bin_count_reg;
        max_count_next = max_count_reg;
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        nb_next        = nb_reg;
        bin_next       = bin_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        pass_next      = pass_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        xq_next   = xq_reg;
        yq_next   = yq_reg;
        t_next    = t_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        mb_next   = mb_reg;
        med_next  = med_reg;
        prod_next = prod_reg;
        diff_next = diff_reg;
        madq_next = madq_reg;
        pres_next = pres_reg;
        pst_next  = pst_reg;
        pkind_next = pkind_reg;
        ores_next = ores_reg;
        ost_next  = ost_reg;
        okind_next = okind_reg;
        smp_we    = 1'b0;
        smp_waddr = fill_reg[SAW-1:0];
        smp_raddr = idx_reg[SAW-1:0];
        scr_we    = 1'b0;
        scr_waddr = n_reg[SAW-1:0];
        scr_wdata = t_reg;
        scr_raddr = idx_reg[SAW-1:0];
        edg_we    = 1'b0;
        edg_waddr = bmm_pkg::EDGE_AW'(idx_reg);
        edg_wdata = div_resp.quotient[EW-1:0];
        edg_raddr = bmm_pkg::EDGE_AW'(bin_reg);
        tbl_we    = 1'b0;
        tbl_addr  = bin_reg[bmm_pkg::TBL_AW-1:0];
        tbl_med   = '0;
        tbl_mad   = '0;
        div_req.start    = 1'b0;
        div_req.dividend = bmm_pkg::DIV_N_W'(acc_reg);
        div_req.divisor  = bmm_pkg::DIV_D_W'(nb_reg);

        if (cfg_we)
        begin
            if (cfg_index == bmm_pkg::CFG_BIN_COUNT)
            begin
                bin_count_next = cfg_data[bmm_pkg::BC_W-1:0];
            end
            else
            begin
                max_count_next = cfg_data;
            end
        end

        unique case (state_reg)
            bmm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    xq_next = x;
                    yq_next = y;
                    if (op == bmm_pkg::OP_LOAD)
                    begin
                        if (fill_reg < FW'(bmm_pkg::MAX_SAMPLES))
                        begin
                            smp_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                        if (last)
                        begin
                            state_next = bmm_pkg::S_F_START;
                        end
                    end
                    else
                    begin
                        state_next = bmm_pkg::S_Q_START;
                    end
                end
            end
            bmm_pkg::S_F_START:
            begin
                nb_next  = nb_calc;
                idx_next = '0;
                acc_next = bmm_pkg::ACC_W'(nb_calc) - 1'b1;
                state_next = (nb_calc == '0) ? bmm_pkg::S_F_END : bmm_pkg::S_E_DIV;
            end
            bmm_pkg::S_E_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = bmm_pkg::S_E_WAIT;
            end
            bmm_pkg::S_E_WAIT:
            begin
                if (div_resp.done)
                begin
                    edg_we = 1'b1;
                    if (idx_reg + 1'b1 == FW'(nb_reg))
                    begin
                        state_next = bmm_pkg::S_E_LAST;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        acc_next   = acc_reg + bmm_pkg::ACC_W'(max_count_reg);
                        state_next = bmm_pkg::S_E_DIV;
                    end
                end
            end
            bmm_pkg::S_E_LAST:
            begin
                edg_we     = 1'b1;
                edg_waddr  = bmm_pkg::EDGE_AW'(nb_reg);
                edg_wdata  = EW'(max_count_reg) + 1'b1;
                bin_next   = '0;
                state_next = bmm_pkg::S_B_EDGE;
            end
            bmm_pkg::S_B_EDGE:
            begin
                state_next = bmm_pkg::S_B_EDGE2;
            end
            bmm_pkg::S_B_EDGE2:
            begin
                lo_next    = edg_rdata;
                edg_raddr  = bmm_pkg::EDGE_AW'(bin_reg + 1'b1);
                state_next = bmm_pkg::S_B_EDGE3;
            end
            bmm_pkg::S_B_EDGE3:
            begin
                hi_next    = edg_rdata;
                idx_next   = '0;
                n_next     = '0;
                state_next = bmm_pkg::S_C_RD;
            end
            bmm_pkg::S_C_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (n_reg == '0)
                    begin
                        tbl_we     = 1'b1;
                        state_next = bmm_pkg::S_B_NEXT;
                    end
                    else
                    begin
                        pass_next  = 1'b0;
                        state_next = bmm_pkg::S_S_INIT;
                    end
                end
                else
                begin
                    state_next = bmm_pkg::S_C_CHK;
                end
            end
            bmm_pkg::S_C_CHK:
            begin
                if (({1'b0, xs_rdata} >= lo_reg) && ({1'b0, xs_rdata} < hi_reg))
                begin
                    scr_we    = 1'b1;
                    scr_wdata = ys_rdata ^ bmm_pkg::SIGN_BIAS;
                    n_next    = n_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = bmm_pkg::S_C_RD;
            end
            bmm_pkg::S_S_INIT:
            begin
                idx_next   = FW'(1);
                state_next = bmm_pkg::S_S_OUTER;
            end
            bmm_pkg::S_S_OUTER:
            begin
                state_next = (idx_reg >= n_reg) ? bmm_pkg::S_M_RD : bmm_pkg::S_S_T;
            end
            bmm_pkg::S_S_T:
            begin
                t_next     = scr_rdata;
                j_next     = idx_reg;
                state_next = bmm_pkg::S_S_INNER;
            end
            bmm_pkg::S_S_INNER:
            begin
                scr_raddr = SAW'(j_reg - 1'b1);
                if (j_reg == '0)
                begin
                    scr_we     = 1'b1;
                    scr_waddr  = '0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = bmm_pkg::S_S_OUTER;
                end
                else
                begin
                    state_next = bmm_pkg::S_S_CMP;
                end
            end
            bmm_pkg::S_S_CMP:
            begin
                scr_we    = 1'b1;
                scr_waddr = j_reg[SAW-1:0];
                if (scr_rdata > t_reg)
                begin
                    scr_wdata  = scr_rdata;
                    j_next     = j_reg - 1'b1;
                    state_next = bmm_pkg::S_S_INNER;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = bmm_pkg::S_S_OUTER;
                end
            end
            bmm_pkg::S_M_RD:
            begin
                scr_raddr  = n_reg[SAW:1];
                state_next = bmm_pkg::S_M_A;
            end
            bmm_pkg::S_M_A:
            begin
                a_next    = scr_rdata;
                scr_raddr = n_reg[SAW:1] - 1'b1;
                if (n_reg[0])
                begin
                    med_next   = scr_rdata;
                    state_next = bmm_pkg::S_M_USE;
                end
                else
                begin
                    state_next = bmm_pkg::S_M_B;
                end
            end
            bmm_pkg::S_M_B:
            begin
                med_next   = med_sum[YW:1];
                state_next = bmm_pkg::S_M_USE;
            end
            bmm_pkg::S_M_USE:
            begin
                if (!pass_reg)
                begin
                    mb_next    = med_reg;
                    idx_next   = '0;
                    state_next = bmm_pkg::S_D_RD;
                end
                else
                begin
                    state_next = bmm_pkg::S_MUL;
                end
            end
            bmm_pkg::S_D_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = bmm_pkg::S_S_INIT;
                end
                else
                begin
                    state_next = bmm_pkg::S_D_WR;
                end
            end
            bmm_pkg::S_D_WR:
            begin
                scr_we     = 1'b1;
                scr_waddr  = idx_reg[SAW-1:0];
                scr_wdata  = (scr_rdata >= mb_reg) ? scr_rdata - mb_reg : mb_reg - scr_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = bmm_pkg::S_D_RD;
            end
            bmm_pkg::S_MUL:
            begin
                prod_next  = med_reg * bmm_pkg::MAD_SCALE;
                state_next = bmm_pkg::S_MUL2;
            end
            bmm_pkg::S_MUL2:
            begin
                tbl_we     = 1'b1;
                tbl_med    = mb_reg ^ bmm_pkg::SIGN_BIAS;
                tbl_mad    = prod_rnd[bmm_pkg::PROD_W-1] ? '1 : prod_rnd[47:16];
                state_next = bmm_pkg::S_B_NEXT;
            end
            bmm_pkg::S_B_NEXT:
            begin
                if (bin_reg + 1'b1 == nb_reg)
                begin
                    state_next = bmm_pkg::S_F_END;
                end
                else
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = bmm_pkg::S_B_EDGE;
                end
            end
            bmm_pkg::S_F_END:
            begin
                pkind_next   = bmm_pkg::KIND_FIT;
                pres_next    = '0;
                pst_next     = (nb_reg == '0) ? bmm_pkg::ST_NO_BINS
                             : (dropped_reg ? bmm_pkg::ST_OVFL : bmm_pkg::ST_OK);
                fill_next    = '0;
                dropped_next = 1'b0;
                state_next   = bmm_pkg::S_OUT;
            end
            bmm_pkg::S_Q_START:
            begin
                pkind_next = bmm_pkg::KIND_RES;
                bin_next   = '0;
                if (nb_reg == '0)
                begin
                    pres_next  = '0;
                    pst_next   = bmm_pkg::ST_NO_BINS;
                    state_next = bmm_pkg::S_OUT;
                end
                else
                begin
                    state_next = bmm_pkg::S_Q_RD;
                end
            end
            bmm_pkg::S_Q_RD:
            begin
                state_next = (bin_reg == nb_reg) ? bmm_pkg::S_Q_SEL : bmm_pkg::S_Q_CMP;
            end
            bmm_pkg::S_Q_CMP:
            begin
                if (edg_rdata <= {1'b0, xq_reg})
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = bmm_pkg::S_Q_RD;
                end
                else
                begin
                    state_next = bmm_pkg::S_Q_SEL;
                end
            end
            bmm_pkg::S_Q_SEL:
            begin
                diff_next  = $signed({yq_reg[YW-1], yq_reg})
                           - $signed({bin_median_reg[qbin][YW-1], bin_median_reg[qbin]});
                madq_next  = bin_mad_reg[qbin];
                state_next = bmm_pkg::S_Q_DIFF;
            end
            bmm_pkg::S_Q_DIFF:
            begin
                if (madq_reg == '0)
                begin
                    pst_next   = bmm_pkg::ST_ZERO;
                    pres_next  = (diff_reg > 0) ? bmm_pkg::SAT_POS
                               : ((diff_reg < 0) ? bmm_pkg::SAT_NEG : '0);
                    state_next = bmm_pkg::S_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {mag, 16'b0} + bmm_pkg::DIV_N_W'(madq_reg[YW-1:1]);
                    div_req.divisor  = madq_reg;
                    state_next       = bmm_pkg::S_Q_WAIT;
                end
            end
            bmm_pkg::S_Q_WAIT:
            begin
                if (div_resp.done)
                begin
                    pst_next = bmm_pkg::ST_OK;
                    if (!diff_reg[YW])
                    begin
                        pres_next = (|div_resp.quotient[bmm_pkg::DIV_N_W-1:YW-1])
                                  ? bmm_pkg::SAT_POS : q_lo;
                    end
                    else
                    begin
                        pres_next = (|div_resp.quotient[bmm_pkg::DIV_N_W-1:YW-1])
                                  ? bmm_pkg::SAT_NEG : YW'(0) - q_lo;
                    end
                    state_next = bmm_pkg::S_OUT;
                end
            end
            bmm_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ores_next      = pres_reg;
                    ost_next       = pst_reg;
                    okind_next     = pkind_reg;
                    state_next     = bmm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmm_pkg::S_IDLE;
            bin_count_reg <= 6'd20;
            max_count_reg <= '0;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            nb_reg        <= '0;
            bin_reg       <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_count_reg <= bin_count_next;
            max_count_reg <= max_count_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            nb_reg        <= nb_next;
            bin_reg       <= bin_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xq_reg    <= xq_next;
        yq_reg    <= yq_next;
        t_reg     <= t_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        mb_reg    <= mb_next;
        med_reg   <= med_next;
        prod_reg  <= prod_next;
        diff_reg  <= diff_next;
        madq_reg  <= madq_next;
        pres_reg  <= pres_next;
        pst_reg   <= pst_next;
        pkind_reg <= pkind_next;
        ores_reg  <= ores_next;
        ost_reg   <= ost_next;
        okind_reg <= okind_next;
        if (tbl_we)
        begin
            bin_median_reg[tbl_addr] <= tbl_med;
            bin_mad_reg[tbl_addr]    <= tbl_mad;
        end
    end

    assign in_stall  = (state_reg != bmm_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = okind_reg;
    assign residual  = ores_reg;
    assign status    = ost_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(bmm_pkg::MAX_SAMPLES))
        else $error("sample fill count exceeds the store depth");

    a_bins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nb_reg <= BW'(bmm_pkg::MAX_BINS))
        else $error("bins in use exceed the table depth");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bmm_pkg::S_OUT))
        else $error("result word appeared outside the output step");

    a_fit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && okind_reg == bmm_pkg::KIND_FIT) |-> fill_reg == '0)
        else $error("sample set not cleared after a fit");
`endif

endmodule

[tb/sv/binned_median_mad_standardiser_test.sv]
// ----------------------------------------------------------------------------
// binned_median_mad_standardiser_test
// Self-checking bench: drives load and query words under several idle and
// stall mixes, predicts every fit and residual word (or takes it from the
// directed table for directed rows), and compares them in order.
module binned_median_mad_standardiser_test;
    import bmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        logic        kind;
        logic [31:0] residual;
        logic [1:0]  status;
    } result_t;

    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        logic        op;
        logic [15:0] x;
        logic [31:0] y;
        logic        last;
        bit          typed;
        result_t     want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [15:0]        x;
    logic signed [31:0] y;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic signed [31:0] residual;
    logic [1:0]         status;

    binned_median_mad_standardiser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .x         (x),
        .y         (y),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .residual  (residual),
        .status    (status)
    );

    // Predictor state.
    int unsigned  bin_count_reg;
    int unsigned  max_count_reg;
    bit [15:0]    sample_x[$];
    bit [31:0]    sample_y[$];
    bit           dropped;
    int unsigned  fitted_bins;
    int unsigned  edge_tbl[MAX_BINS+1];
    bit [31:0]    median_tbl[MAX_BINS];
    bit [31:0]    mad_tbl[MAX_BINS];

    result_t      pending[$];
    int           errors;
    int           checked;
    int           n_loads;
    int           n_queries;
    int           n_fits;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_reqs;
    int           hold_seen;
    int           hold_left;
    int           quiet_cycles;
    row_t         rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit [31:0] middle_of(bit [31:0] v[$]);
        int unsigned n;
        bit [32:0]   s;
        n = v.size();
        if (n % 2 == 1)
            return v[n/2];
        s = {1'b0, v[n/2-1]} + {1'b0, v[n/2]};
        return s[32:1];
    endfunction

    function automatic logic [1:0] fit_bins();
        int unsigned nb;
        bit [31:0]   vals[$];
        bit [31:0]   mb;
        bit [31:0]   d;
        bit [63:0]   scaled;
        logic [1:0]  st;
        nb = bin_count_reg;
        if (nb > max_count_reg)
            nb = max_count_reg;
        if (nb > MAX_BINS)
            nb = MAX_BINS;
        fitted_bins = nb;
        if (nb > 0)
        begin
            for (int i = 0; i < nb; i++)
                edge_tbl[i] = (max_count_reg * i + nb - 1) / nb;
            edge_tbl[nb] = max_count_reg + 1;
            for (int b = 0; b < nb; b++)
            begin
                vals.delete();
                foreach (sample_x[i])
                    if (sample_x[i] >= edge_tbl[b] && sample_x[i] < edge_tbl[b+1])
                        vals.push_back(sample_y[i] ^ SIGN_BIAS);
                if (vals.size() == 0)
                begin
                    median_tbl[b] = '0;
                    mad_tbl[b] = '0;
                end
                else
                begin
                    vals.sort();
                    mb = middle_of(vals);
                    foreach (vals[i])
                        vals[i] = (vals[i] >= mb) ? vals[i] - mb : mb - vals[i];
                    vals.sort();
                    d = middle_of(vals);
                    scaled = (64'(d) * 64'(MAD_SCALE) + 64'd32768) >> 16;
                    if (scaled > 64'hFFFF_FFFF)
                        scaled = 64'hFFFF_FFFF;
                    median_tbl[b] = mb ^ SIGN_BIAS;
                    mad_tbl[b] = scaled[31:0];
                end
            end
        end
        st = (nb == 0) ? ST_NO_BINS : (dropped ? ST_OVFL : ST_OK);
        sample_x.delete();
        sample_y.delete();
        dropped = 1'b0;
        return st;
    endfunction

    function automatic bit predict_word(logic o, logic [15:0] xv, logic [31:0] yv,
                                        logic lst, output result_t r);
        int unsigned b;
        longint      diff;
        bit [63:0]   mag;
        bit [63:0]   q;
        bit [31:0]   m;
        r.kind = KIND_RES;
        r.residual = '0;
        r.status = ST_OK;
        if (o == OP_LOAD)
        begin
            if (sample_x.size() < MAX_SAMPLES)
            begin
                sample_x.push_back(xv);
                sample_y.push_back(yv);
            end
            else
                dropped = 1'b1;
            if (!lst)
                return 1'b0;
            r.kind = KIND_FIT;
            r.status = fit_bins();
            return 1'b1;
        end
        if (fitted_bins == 0)
        begin
            r.status = ST_NO_BINS;
            return 1'b1;
        end
        b = 0;
        while (b < fitted_bins && edge_tbl[b] <= xv)
            b++;
        if (b > 0)
            b--;
        diff = longint'($signed(yv)) - longint'($signed(median_tbl[b]));
        m = mad_tbl[b];
        if (m == 0)
        begin
            r.residual = diff > 0 ? SAT_POS : (diff < 0 ? SAT_NEG : 32'd0);
            r.status = ST_ZERO;
            return 1'b1;
        end
        mag = diff < 0 ? -diff : diff;
        q = ((mag << 16) + 64'(m >> 1)) / 64'(m);
        if (diff >= 0)
            r.residual = q > 64'h7FFF_FFFF ? SAT_POS : q[31:0];
        else
            r.residual = q >= 64'h8000_0000 ? SAT_NEG : 32'd0 - q[31:0];
        return 1'b1;
    endfunction

    task automatic send_word(logic o, logic [15:0] xv, logic [31:0] yv, logic lst,
                             bit typed = 0, result_t want = '{default: '0});
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        x <= xv;
        y <= yv;
        last <= lst;
        do
            @(posedge clk);
        while (in_stall);
        if (o == OP_LOAD)
            n_loads++;
        else
            n_queries++;
        if (predict_word(o, xv, yv, lst, r))
        begin
            if (r.kind == KIND_FIT)
                n_fits++;
            pending.push_back(typed ? want : r);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BIN_COUNT)
            bin_count_reg = val & 32'h3F;
        else
            max_count_reg = val & 32'hFFFF;
    endtask

    function automatic row_t word_row(logic o, logic [15:0] xv, logic [31:0] yv,
                                      logic lst, bit typed = 0, logic k = 0,
                                      logic [31:0] res = 0, logic [1:0] st = 0);
        row_t r;
        r = '{default: '0};
        r.op = o;
        r.x = xv;
        r.y = yv;
        r.last = lst;
        r.typed = typed;
        r.want = '{k, res, st};
        return r;
    endfunction

    function automatic row_t cfg_row(logic idx, logic [15:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // Random sample set followed by queries against it.
    task automatic random_set(int nsamp, int nq);
        logic [31:0] base;
        logic [31:0] spread;
        logic [15:0] xv;
        base = $urandom();
        spread = 32'd1 << $urandom_range(31, 4);
        for (int i = 0; i < nsamp; i++)
        begin
            if ($urandom_range(9) == 0)
                xv = $urandom();
            else
                xv = $urandom_range(max_count_reg, 0);
            send_word(OP_LOAD, xv,
                      $urandom_range(7) == 0 ? $urandom() : base + ($urandom() % spread),
                      i == nsamp - 1);
        end
        for (int i = 0; i < nq; i++)
        begin
            xv = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(max_count_reg, 0));
            send_word(OP_QUERY, xv,
                      $urandom_range(3) == 0 ? $urandom() : base + ($urandom() % spread),
                      1'($urandom()));
        end
    endtask

    task automatic random_config();
        int unsigned bc;
        int unsigned mc;
        case ($urandom_range(5))
            0: bc = 1;
            1: bc = 32;
            2: bc = 63;
            3: bc = 0;
            default: bc = $urandom_range(31, 2);
        endcase
        case ($urandom_range(6))
            0: mc = 0;
            1: mc = 1;
            2: mc = 65535;
            3: mc = $urandom_range(65535);
            default: mc = $urandom_range(200, 2);
        endcase
        write_reg(CFG_BIN_COUNT, bc);
        write_reg(CFG_MAX_COUNT, mc);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result word: kind %0d residual %h status %0d",
                             kind, residual, status);
            end
            else
            begin
                w = pending.pop_front();
                if (kind !== w.kind || residual !== w.residual || status !== w.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected kind %0d residual %h status %0d, got kind %0d residual %h status %0d",
                                 w.kind, w.residual, w.status, kind, residual, status);
                end
            end
        end
        out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAIL binned_median_mad_standardiser");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_LOAD;
        x = '0;
        y = '0;
        last = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        checked = 0;
        n_loads = 0;
        n_queries = 0;
        n_fits = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs = 0;
        quiet_cycles = 0;
        bin_count_reg = 20;
        max_count_reg = 0;
        dropped = 1'b0;
        fitted_bins = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words.
        rows.push_back(word_row(OP_QUERY, 16'd0, 32'd5, 1'b0, 1, KIND_RES, 0, ST_NO_BINS));
        rows.push_back(word_row(OP_LOAD, 16'd3, 32'd7, 1'b1, 1, KIND_FIT, 0, ST_NO_BINS));
        rows.push_back(word_row(OP_QUERY, 16'hFFFF, 32'h8000_0000, 1'b1, 1, KIND_RES, 0,
                                ST_NO_BINS));
        rows.push_back(cfg_row(CFG_BIN_COUNT, 16'd4));
        rows.push_back(cfg_row(CFG_MAX_COUNT, 16'd100));
        rows.push_back(word_row(OP_LOAD, 16'd0, 32'h7FFF_FFFF, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'd100, 32'h8000_0000, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'd50, 32'd1, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'd50, 32'd3, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'd60, 32'd40000, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'd25, 32'hFFFF_FFFB, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'hFFFF, 32'd9, 1'b1));
        rows.push_back(word_row(OP_QUERY, 16'd0, 32'h7FFF_FFFF, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'd0, 32'h8000_0000, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'hFFFF, 32'h8000_0000, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'd50, 32'd2, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'd55, 32'h7FFF_FFFF, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'd25, 32'hFFFF_FFFB, 1'b0));
        rows.push_back(cfg_row(CFG_BIN_COUNT, 16'd63));
        rows.push_back(cfg_row(CFG_MAX_COUNT, 16'hFFFF));
        rows.push_back(word_row(OP_LOAD, 16'h8000, 32'h0001_0000, 1'b0));
        rows.push_back(word_row(OP_LOAD, 16'h8001, 32'hFFFF_0000, 1'b1));
        rows.push_back(word_row(OP_QUERY, 16'h8000, 32'd0, 1'b0));
        rows.push_back(word_row(OP_QUERY, 16'hFFFF, 32'd0, 1'b0));
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            end
            else
                send_word(rows[i].op, rows[i].x, rows[i].y, rows[i].last,
                          rows[i].typed, rows[i].want);
        end

        // Store overflow: one more pair than the store holds, all with equal y value.
        wait_idle();
        write_reg(CFG_BIN_COUNT, 1);
        write_reg(CFG_MAX_COUNT, 65535);
        for (int i = 0; i <= MAX_SAMPLES; i++)
            send_word(OP_LOAD, 16'($urandom()), 32'h0000_1234, i == MAX_SAMPLES);
        send_word(OP_QUERY, 16'd7, 32'h0000_1235, 1'b0);

        // Random sets under each idle and stall mix.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 24 : 67) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 24 : 67) : 0;
            for (int s = 0; s < 12; s++)
            begin
                wait_idle();
                random_config();
                if (s == 5)
                    hold_reqs <= hold_reqs + 1;
                random_set($urandom_range(30, 1), $urandom_range(14, 2));
            end
        end

        wait_idle();
        repeat (200) @(posedge clk);
        $display("Covered %0d loads, %0d queries and %0d fits; %0d result words checked.",
                 n_loads, n_queries, n_fits, checked);
        $display("Runs included store overflow, no-bin, clamp and receiver hold-off cases.");
        if (errors == 0 && pending.size() == 0)
            $display("PASS binned_median_mad_standardiser");
        else
            $display("FAIL binned_median_mad_standardiser");
        $finish;
    end

endmodule
